// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/bpla_pkg.sv -----
package bpla_pkg;

  typedef enum logic [1:0] {
    ST_OK            = 2'd0,
    ST_OUT_OF_BOUND  = 2'd1,
    ST_NOT_IN_BUFFER = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_DIRTY  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    COMMIT_NONE  = 2'd0,
    COMMIT_ALLOC = 2'd1,
    COMMIT_DIRTY = 2'd2
  } commit_op_t;

  // Register index of the disk size register.
  localparam logic REG_DISK_BLOCK_COUNT = 1'b0;

  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 3;

endpackage

// ----- rtl/buffer_pool_lru_allocator.sv -----
// Buffer pool slot allocator with timestamp LRU replacement.
// Requests enter on in_valid/in_stall with cmd and block_number; one result
// per request leaves on out_valid/out_stall with status, slot_index,
// writeback and writeback_block. A request is taken when valid is high and
// stall is low.
// Slot state lives in a row of SLOT_COUNT cells. A request sends a scan
// record down the row, one cell per cycle, collecting the first free slot,
// the oldest slot and the first matching slot; the last cell's record
// decides the result and the chosen cell is updated with the result register.
// A scanning request passes the scan_go register and the row of cells, then
// S_FINISH, before its result is registered; an out-of-bound request goes
// straight to S_FINISH. One request is in flight at a time: in_stall stays
// high from the accept until S_FINISH hands the result to the result register.
// The result register is separate: a new request may be taken while a
// finished result waits, but its own result and state update hold while
// out_stall stays high.
// Reset (synchronous, rst high) frees every slot, clears dirty bits and
// ages, and sets the disk size register to 2**BLOCK_ADDR_BITS.
// The disk size register is at byte address 0 on the APB port.
module buffer_pool_lru_allocator
  import bpla_pkg::*;
#(
  parameter int SLOT_COUNT      = 32,
  parameter int BLOCK_ADDR_BITS = 13,
  parameter int AGE_BITS        = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [APB_ADDR_BITS-1:0]      paddr,
  input  logic [APB_DATA_BITS-1:0]      pwdata,
  output logic [APB_DATA_BITS-1:0]      prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    cmd,
  input  logic [BLOCK_ADDR_BITS-1:0]    block_number,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    status,
  output logic [$clog2(SLOT_COUNT)-1:0] slot_index,
  output logic                          writeback,
  output logic [BLOCK_ADDR_BITS-1:0]    writeback_block
);

  localparam int IDX_BITS = $clog2(SLOT_COUNT);

  typedef struct packed {
    logic                       free_found;
    logic [IDX_BITS-1:0]        free_idx;
    logic [IDX_BITS-1:0]        best_idx;
    logic [AGE_BITS-1:0]        best_age;
    logic                       best_dirty;
    logic [BLOCK_ADDR_BITS-1:0] best_block;
    logic                       hit;
    logic [IDX_BITS-1:0]        hit_idx;
  } carry_t;

  typedef struct packed {
    commit_op_t                 op;
    logic [IDX_BITS-1:0]        idx;
    logic [BLOCK_ADDR_BITS-1:0] block;
  } commit_t;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t                     state;
  state_t                     state_next;
  logic [BLOCK_ADDR_BITS:0]   disk_block_count;
  logic [1:0]                 req_cmd;
  logic [BLOCK_ADDR_BITS-1:0] req_block;
  logic                       req_oob;
  logic                       scan_go;
  logic                       accept;
  logic                       in_oob;
  logic                       out_free;
  logic                       finish;
  commit_t                    commit;
  carry_t                     chain     [SLOT_COUNT+1];
  logic                       chain_vld [SLOT_COUNT+1];
  carry_t                     tail;

  logic [1:0]                 res_status;
  logic [IDX_BITS-1:0]        res_slot;
  logic                       res_wb;
  logic [BLOCK_ADDR_BITS-1:0] res_wb_block;

  bpla_cfg #(
    .BLOCK_ADDR_BITS(BLOCK_ADDR_BITS)
  ) u_cfg (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .disk_block_count (disk_block_count)
  );

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign in_oob   = ({1'b0, block_number} >= disk_block_count);
  assign out_free = !out_valid || !out_stall;
  assign finish   = (state == S_FINISH) && out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = in_oob ? S_FINISH : S_SCAN;
        end
      end
      S_SCAN: begin
        if (chain_vld[SLOT_COUNT]) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      scan_go <= 1'b0;
    end else begin
      state   <= state_next;
      scan_go <= accept && !in_oob;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_cmd   <= cmd;
      req_block <= block_number;
      req_oob   <= in_oob;
    end
  end

  assign chain[0]     = '0;
  assign chain_vld[0] = scan_go;
  assign tail         = chain[SLOT_COUNT];

  for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
    bpla_cell #(
      .IDX_BITS        (IDX_BITS),
      .BLOCK_ADDR_BITS (BLOCK_ADDR_BITS),
      .AGE_BITS        (AGE_BITS),
      .IDX             (g),
      .carry_t         (carry_t),
      .commit_t        (commit_t)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .req_block (req_block),
      .commit    (commit),
      .cin_vld   (chain_vld[g]),
      .cin       (chain[g]),
      .cout_vld  (chain_vld[g+1]),
      .cout      (chain[g+1])
    );
  end

  // result and cell update from the last cell's scan record, or out-of-bound status
  always_comb begin
    res_status   = ST_OK;
    res_slot     = '0;
    res_wb       = 1'b0;
    res_wb_block = '0;
    commit.op    = COMMIT_NONE;
    commit.idx   = '0;
    commit.block = req_block;
    if (req_oob) begin
      res_status = ST_OUT_OF_BOUND;
    end else begin
      case (req_cmd)
        CMD_ALLOC: begin
          commit.op = COMMIT_ALLOC;
          if (tail.free_found) begin
            res_slot = tail.free_idx;
          end else begin
            res_slot = tail.best_idx;
            res_wb   = tail.best_dirty;
            if (tail.best_dirty) begin
              res_wb_block = tail.best_block;
            end
          end
          commit.idx = res_slot;
        end
        default: begin
          // lookup and set-dirty; the unused code behaves as lookup
          if (tail.hit) begin
            res_slot   = tail.hit_idx;
            commit.idx = tail.hit_idx;
            if (req_cmd == CMD_DIRTY) begin
              commit.op = COMMIT_DIRTY;
            end
          end else begin
            res_status = ST_NOT_IN_BUFFER;
          end
        end
      endcase
    end
    if (!finish) begin
      commit.op = COMMIT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      status          <= res_status;
      slot_index      <= res_slot;
      writeback       <= res_wb;
      writeback_block <= res_wb_block;
    end
  end

endmodule

// ----- rtl/bpla_cfg.sv -----
module bpla_cfg
  import bpla_pkg::*;
#(
  parameter int BLOCK_ADDR_BITS = 13
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [APB_ADDR_BITS-1:0]     paddr,
  input  logic [APB_DATA_BITS-1:0]     pwdata,
  output logic [APB_DATA_BITS-1:0]     prdata,
  output logic                         pready,
  output logic [BLOCK_ADDR_BITS:0]     disk_block_count
);

  localparam int CNT_BITS = BLOCK_ADDR_BITS + 1;

  logic                                reg_sel;
  logic [CNT_BITS+APB_DATA_BITS-1:0]   wdata_ext;
  logic [CNT_BITS+APB_DATA_BITS-1:0]   rdata_ext;

  // registers sit at 4-byte steps; bit 2 picks the register
  assign reg_sel   = (paddr[2] == REG_DISK_BLOCK_COUNT);
  assign wdata_ext = {{CNT_BITS{1'b0}}, pwdata};
  assign rdata_ext = {{APB_DATA_BITS{1'b0}}, disk_block_count};
  assign pready    = 1'b1;
  assign prdata    = reg_sel ? rdata_ext[APB_DATA_BITS-1:0] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      disk_block_count <= CNT_BITS'(1) << BLOCK_ADDR_BITS;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      disk_block_count <= wdata_ext[CNT_BITS-1:0];
    end
  end

endmodule

// ----- rtl/bpla_cell.sv -----
module bpla_cell
  import bpla_pkg::*;
#(
  parameter int  IDX_BITS        = 5,
  parameter int  BLOCK_ADDR_BITS = 13,
  parameter int  AGE_BITS        = 16,
  parameter int  IDX             = 0,
  parameter type carry_t         = logic,
  parameter type commit_t        = logic
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [BLOCK_ADDR_BITS-1:0] req_block,
  input  commit_t                    commit,
  input  logic                       cin_vld,
  input  carry_t                     cin,
  output logic                       cout_vld,
  output carry_t                     cout
);

  localparam logic [IDX_BITS-1:0] MY_IDX  = IDX_BITS'(IDX);
  localparam logic [AGE_BITS-1:0] AGE_TOP = '1;

  logic                       occupied;
  logic                       dirty;
  logic [AGE_BITS-1:0]        age;
  logic [BLOCK_ADDR_BITS-1:0] block;
  logic [AGE_BITS-1:0]        aged;
  carry_t                     cout_next;

  // age as it will be once this allocate has aged the pool
  assign aged = (occupied && age != AGE_TOP) ? age + 1'b1 : age;

  always_comb begin
    cout_next = cin;
    if (!occupied && !cin.free_found) begin
      cout_next.free_found = 1'b1;
      cout_next.free_idx   = MY_IDX;
    end
    // strict compare keeps the lowest slot on a tie
    if (IDX == 0 || aged > cin.best_age) begin
      cout_next.best_idx   = MY_IDX;
      cout_next.best_age   = aged;
      cout_next.best_dirty = dirty;
      cout_next.best_block = block;
    end
    if (occupied && block == req_block && !cin.hit) begin
      cout_next.hit     = 1'b1;
      cout_next.hit_idx = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cout_vld <= 1'b0;
    end else begin
      cout_vld <= cin_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (cin_vld) begin
      cout <= cout_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupied <= 1'b0;
      dirty    <= 1'b0;
      age      <= '0;
    end else begin
      case (commit.op)
        COMMIT_ALLOC: begin
          if (commit.idx == MY_IDX) begin
            occupied <= 1'b1;
            dirty    <= 1'b0;
            age      <= '0;
          end else begin
            age <= aged;
          end
        end
        COMMIT_DIRTY: begin
          if (commit.idx == MY_IDX) begin
            dirty <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (commit.op == COMMIT_ALLOC && commit.idx == MY_IDX) begin
      block <= commit.block;
    end
  end

endmodule

// ----- rtl/bpla_checker.sv -----
`include "assert_macros.svh"

module bpla_checker
  import bpla_pkg::*;
#(
  parameter int SLOT_COUNT      = 32,
  parameter int BLOCK_ADDR_BITS = 13
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [1:0]                    status,
  input logic [$clog2(SLOT_COUNT)-1:0] slot_index,
  input logic                          writeback,
  input logic [BLOCK_ADDR_BITS-1:0]    writeback_block
);

  // a write-back only comes with a successful allocate
  `ASSERT_IMPLIES(a_wb_ok, clk, rst, out_valid && writeback, status == ST_OK)

  // failed requests report slot zero and no write-back
  `ASSERT_IMPLIES(a_fail_zero, clk, rst, out_valid && status != ST_OK, slot_index == '0 && !writeback)

  `ASSERT_IMPLIES(a_wb_block_zero, clk, rst, out_valid && !writeback, writeback_block == '0)

  // one request at a time: the port closes right after an accept
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)

  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(status) && $stable(slot_index))

endmodule

bind buffer_pool_lru_allocator bpla_checker #(
  .SLOT_COUNT      (SLOT_COUNT),
  .BLOCK_ADDR_BITS (BLOCK_ADDR_BITS)
) u_bpla_checker (.*);

// ----- test/testbench.sv -----
module testbench;
  import bpla_pkg::*;

  localparam int SLOTS      = 32;
  localparam int BLOCK_BITS = 13;
  localparam int AGE_BITS   = 16;
  localparam int SLOT_BITS  = $clog2(SLOTS);

  localparam logic [AGE_BITS-1:0] AGE_MAX = '1;
  localparam logic [1:0] CMD_UNUSED = 2'd3;  // decoded by the block as a lookup
  localparam logic [APB_ADDR_BITS-1:0] DISK_SIZE_ADDR =
    APB_ADDR_BITS'(4 * REG_DISK_BLOCK_COUNT);
  localparam logic [13:0] DISK_SIZE_FULL = 14'd8192;

  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_PRINTED = 30;
  localparam int PHASE_ITEMS = 250;
  localparam int ITEMS_PER_DISK_SIZE = 60;

  typedef struct {
    status_t               st;
    logic [SLOT_BITS-1:0]  slot;
    logic                  wb;
    logic [BLOCK_BITS-1:0] wb_blk;
  } pool_resp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                     psel    = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite  = 1'b0;
  logic [APB_ADDR_BITS-1:0] paddr   = '0;
  logic [APB_DATA_BITS-1:0] pwdata  = '0;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;

  logic                  in_valid     = 1'b0;
  logic                  in_stall;
  logic [1:0]            cmd          = '0;
  logic [BLOCK_BITS-1:0] block_number = '0;
  logic                  out_valid;
  logic                  out_stall    = 1'b0;
  logic [1:0]            status;
  logic [SLOT_BITS-1:0]  slot_index;
  logic                  writeback;
  logic [BLOCK_BITS-1:0] writeback_block;

  // pool model
  logic                  pool_occupied [SLOTS];
  logic                  pool_dirty    [SLOTS];
  logic [AGE_BITS-1:0]   pool_age      [SLOTS];
  logic [BLOCK_BITS-1:0] pool_block    [SLOTS];
  logic [13:0]           pool_disk_size;

  pool_resp_t expected_responses [$];

  int errors            = 0;
  int cycle_count       = 0;
  int requests_sent     = 0;
  int responses_checked = 0;
  int writebacks_seen   = 0;
  int out_of_bound_seen = 0;
  int disk_size_writes  = 0;
  int send_idle_pct     = 0;
  int stall_pct         = 0;

  buffer_pool_lru_allocator #(
    .SLOT_COUNT(SLOTS),
    .BLOCK_ADDR_BITS(BLOCK_BITS),
    .AGE_BITS(AGE_BITS)
  ) DUT (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycle_count, expected_responses.size());
      $display("buffer_pool_lru_allocator test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic report_mismatch(input string msg);
    // print only the first few, keep counting
    if (errors < MAX_PRINTED) $display("MISMATCH @%0d: %s", cycle_count, msg);
    errors++;
  endtask

  function automatic void reset_pool_model();
    for (int i = 0; i < SLOTS; i++) begin
      pool_occupied[i] = 1'b0;
      pool_dirty[i]    = 1'b0;
      pool_age[i]      = '0;
      pool_block[i]    = '0;
    end
    pool_disk_size = DISK_SIZE_FULL;
  endfunction

  // Applies one request to the pool model and returns the expected response.
  function automatic pool_resp_t apply_pool_request(input logic [1:0] op,
                                                    input logic [BLOCK_BITS-1:0] blk);
    pool_resp_t r;
    int pick;
    r.st     = ST_OK;
    r.slot   = '0;
    r.wb     = 1'b0;
    r.wb_blk = '0;
    pick     = -1;
    if ({1'b0, blk} >= pool_disk_size) begin
      r.st = ST_OUT_OF_BOUND;
    end else if (op == CMD_ALLOC) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (pool_occupied[i] && pool_age[i] != AGE_MAX) pool_age[i]++;
      end
      for (int i = 0; i < SLOTS; i++) begin
        if (pick < 0 && !pool_occupied[i]) pick = i;
      end
      if (pick < 0) begin
        // pool full: evict oldest, lowest index wins a tie
        pick = 0;
        for (int i = 1; i < SLOTS; i++) begin
          if (pool_age[i] > pool_age[pick]) pick = i;
        end
        if (pool_dirty[pick]) begin
          r.wb     = 1'b1;
          r.wb_blk = pool_block[pick];
        end
      end
      pool_occupied[pick] = 1'b1;
      pool_dirty[pick]    = 1'b0;
      pool_age[pick]      = '0;
      pool_block[pick]    = blk;
      r.slot = SLOT_BITS'(pick);
    end else begin
      for (int i = 0; i < SLOTS; i++) begin
        if (pick < 0 && pool_occupied[i] && pool_block[i] == blk) pick = i;
      end
      if (pick < 0) begin
        r.st = ST_NOT_IN_BUFFER;
      end else begin
        if (op == CMD_DIRTY) pool_dirty[pick] = 1'b1;
        r.slot = SLOT_BITS'(pick);
      end
    end
    return r;
  endfunction

  task automatic send_request(input logic [1:0] op, input logic [BLOCK_BITS-1:0] blk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    cmd          <= op;
    block_number <= blk;
    do @(posedge clk); while (in_stall !== 1'b0);
    expected_responses.push_back(apply_pool_request(op, blk));
    requests_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_responses.size() != 0);
  endtask

  // APB write of the disk size, then read it back
  task automatic set_disk_size(input logic [13:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= DISK_SIZE_ADDR;
    pwdata  <= APB_DATA_BITS'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    pool_disk_size = value;
    disk_size_writes++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== APB_DATA_BITS'(value))
      report_mismatch($sformatf("disk size reads %0d, wrote %0d", prdata, value));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic random_request(output logic [1:0] op, output logic [BLOCK_BITS-1:0] blk);
    int roll;
    int s;
    roll = $urandom_range(99);
    if (roll < 45) op = CMD_ALLOC;
    else if (roll < 70) op = CMD_LOOKUP;
    else if (roll < 94) op = CMD_DIRTY;
    else op = CMD_UNUSED;
    roll = $urandom_range(99);
    s = $urandom_range(SLOTS - 1);
    if (roll < 10 || pool_disk_size == 0) begin
      blk = BLOCK_BITS'($urandom);
    end else if (roll < 55 && pool_occupied[s]) begin
      // reuse a held block: hits for lookups, duplicates for allocates
      blk = pool_block[s];
    end else begin
      blk = BLOCK_BITS'($urandom_range(int'(pool_disk_size) - 1));
    end
  endtask

  task automatic test_empty_pool();
    send_request(CMD_LOOKUP, 13'd5);
    send_request(CMD_DIRTY, 13'h1FFF);
    send_request(CMD_UNUSED, 13'd0);
  endtask

  task automatic test_allocate_and_find();
    send_request(CMD_ALLOC, 13'd0);
    send_request(CMD_ALLOC, 13'h1FFF);
    send_request(CMD_ALLOC, 13'd0);
    send_request(CMD_LOOKUP, 13'd0);
    send_request(CMD_UNUSED, 13'h1FFF);
    send_request(CMD_DIRTY, 13'd0);
    send_request(CMD_LOOKUP, 13'd0);
    send_request(CMD_ALLOC, 13'h1555);
    send_request(CMD_ALLOC, 13'h0AAA);
    wait_idle();
  endtask

  task automatic test_disk_bounds();
    set_disk_size(14'd8191);
    send_request(CMD_ALLOC, 13'h1FFF);
    send_request(CMD_LOOKUP, 13'h1FFF);
    send_request(CMD_DIRTY, 13'h1FFE);
    wait_idle();
    // zero size: everything is out of bound
    set_disk_size(14'd0);
    send_request(CMD_ALLOC, 13'd0);
    send_request(CMD_LOOKUP, 13'd0);
    wait_idle();
    set_disk_size(14'd1);
    send_request(CMD_ALLOC, 13'd0);
    send_request(CMD_ALLOC, 13'd1);
    send_request(CMD_DIRTY, 13'd0);
    wait_idle();
    set_disk_size(DISK_SIZE_FULL);
  endtask

  task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
    logic [1:0] op;
    logic [BLOCK_BITS-1:0] blk;
    int roll;
    send_idle_pct = send_pct;
    stall_pct     = recv_pct;
    for (int n = 0; n < count; n++) begin
      if (n != 0 && n % ITEMS_PER_DISK_SIZE == 0) begin
        wait_idle();
        roll = $urandom_range(99);
        if (roll < 30) set_disk_size(DISK_SIZE_FULL);
        else if (roll < 40) set_disk_size(14'd8191);
        else if (roll < 50) set_disk_size(14'd1);
        else if (roll < 70) set_disk_size(14'($urandom_range(1, 64)));
        else set_disk_size(14'($urandom_range(1, 8192)));
      end
      random_request(op, blk);
      send_request(op, blk);
    end
    wait_idle();
  endtask

  always @(posedge clk) begin : check_responses
    pool_resp_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_responses.size() == 0) begin
        report_mismatch("response with no request outstanding");
      end else begin
        want = expected_responses.pop_front();
        if (status !== want.st)
          report_mismatch($sformatf("response %0d: status %0d, expected %0d",
                                    responses_checked, status, want.st));
        if (slot_index !== want.slot)
          report_mismatch($sformatf("response %0d: slot %0d, expected %0d",
                                    responses_checked, slot_index, want.slot));
        if (writeback !== want.wb)
          report_mismatch($sformatf("response %0d: writeback %0d, expected %0d",
                                    responses_checked, writeback, want.wb));
        if (writeback_block !== want.wb_blk)
          report_mismatch($sformatf("response %0d: writeback block %0d, expected %0d",
                                    responses_checked, writeback_block, want.wb_blk));
        if (want.wb) writebacks_seen++;
        if (want.st == ST_OUT_OF_BOUND) out_of_bound_seen++;
        responses_checked++;
      end
    end
  end

  initial begin
    reset_pool_model();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 9;
    stall_pct     = 61;
    set_disk_size(DISK_SIZE_FULL);
    test_empty_pool();
    test_allocate_and_find();
    test_disk_bounds();

    test_random_traffic(PHASE_ITEMS, 9, 61);
    test_random_traffic(PHASE_ITEMS, 61, 9);
    test_random_traffic(PHASE_ITEMS, 0, 0);

    wait_idle();
    repeat (SLOTS + 8) @(posedge clk);

    $display("%0d requests, %0d responses checked: %0d write-backs, %0d out of bound",
             requests_sent, responses_checked, writebacks_seen, out_of_bound_seen);
    $display("%0d disk size writes, %0d mismatches", disk_size_writes, errors);
    if (errors == 0) begin
      $display("buffer_pool_lru_allocator test passed");
    end else begin
      $display("buffer_pool_lru_allocator test failed");
    end
    $finish;
  end

endmodule
